/* sv/oqrk_pkg.sv */
// ----------------------------------------------------------------------------
// oqrk_pkg
// Shared types and constants of the ordered queue with delete by key.
// ----------------------------------------------------------------------------
package oqrk_pkg;

	// default number of queue slots
	localparam int unsigned CAPACITY_DEF = 64;

	// most result words one drain emits
	localparam int unsigned MAX_RESULTS = 64;
	localparam int unsigned RES_W       = $clog2(MAX_RESULTS + 1);

	localparam int unsigned IDENT_W = 32;
	// stored entry: valid flag above the identifier
	localparam int unsigned ENTRY_W = IDENT_W + 1;

	// operation codes
	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_DRAIN  = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic [1:0]         operation;
		logic [IDENT_W-1:0] ident;
	} in_word_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [IDENT_W-1:0] entry_ident;
		logic               entry_valid;
		logic               last;
	} out_word_t;

endpackage

/* sv/oqrk_ram.sv */
// ----------------------------------------------------------------------------
// oqrk_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module oqrk_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, hold when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/oqrk_out_reg.sv */
// ----------------------------------------------------------------------------
// oqrk_out_reg
// Result output register: holds one word until the receiver takes it.
// ----------------------------------------------------------------------------
module oqrk_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  oqrk_pkg::out_word_t load_data,
	output logic               can_load,
	output logic               out_valid,
	input  logic               out_ready,
	output oqrk_pkg::out_word_t out_data
);
	import oqrk_pkg::*;

	logic      valid_q;
	out_word_t data_q;

	// free when empty or the held word leaves this cycle
	assign can_load = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			data_q <= load_data;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

/* sv/ordered_queue_remove_by_key_top.sv */
// ----------------------------------------------------------------------------
// ordered_queue_remove_by_key_top
// Arrival-ordered identifier queue with append, remove by key and drain.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (in_valid/in_ready) carry an operation and an identifier.
//   Result words (out_valid/out_ready) carry status, a drained identifier,
//   its valid flag and a last flag on the final word of each input word.
//   The block takes one input word at a time; in_ready is low while a word
//   is being worked on.
//   Append and unknown codes: one result, loaded into the result register
//   from the final state; the next input word is taken once it is loaded.
//   Remove and drain: one RAM read per used slot through a single read
//   port, pipelined one slot a cycle while a drain is not stalled; a
//   remove ends early at the first match. Drain emits one word per valid
//   slot (at most 64), the last one flagged, then empties the queue.
//   Slots freed by remove stay used until the next drain.
//   Reset clears the tail pointer and control state; the slot RAM needs no
//   clearing, since only slots below the tail are ever read.
//   A stalled receiver holds the result register; a drain pauses its scan
//   until the pending word can be handed on, nothing is dropped.
// ----------------------------------------------------------------------------
module ordered_queue_remove_by_key_top #(
	parameter int unsigned CAPACITY = oqrk_pkg::CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  oqrk_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output oqrk_pkg::out_word_t out_data
);
	import oqrk_pkg::*;

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam int unsigned AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_SCAN  = 3'b010,
		S_FINAL = 3'b100
	} state_t;

	state_t             state_q;
	logic [1:0]         op_q;
	logic [IDENT_W-1:0] key_q;
	logic [CNT_W-1:0]   tail_q;
	logic [CNT_W-1:0]   scan_idx_q;
	logic               chk_valid_s1;
	logic [AW-1:0]      chk_idx_s1;
	logic               pend_valid_q;
	logic [IDENT_W-1:0] pend_ident_q;
	logic [RES_W-1:0]   found_q;
	out_word_t          res_q;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic               ram_re;
	logic [ENTRY_W-1:0] ram_rdata;

	logic      accept;
	logic      is_full;
	logic      app_write;
	logic      is_drain;
	logic      key_hit;
	logic      scan_done;
	logic      chk_go;
	logic      drain_hit;
	logic      remove_hit;
	logic      emit_mid;
	logic      stall;
	logic      issue;
	logic      out_load;
	logic      can_load;
	out_word_t load_data;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign is_full  = (tail_q == CNT_W'(CAPACITY));
	assign app_write = accept && (in_data.operation == OP_APPEND) && !is_full;
	assign is_drain = (op_q == OP_DRAIN);

	// compare unit: stored entry valid and equal to the key
	assign key_hit = ram_rdata[IDENT_W] && (ram_rdata[IDENT_W-1:0] == key_q);

	// scan control
	assign scan_done = (!chk_valid_s1 && (scan_idx_q == tail_q)) ||
		(is_drain && (found_q == RES_W'(MAX_RESULTS)));
	assign chk_go     = (state_q == S_SCAN) && chk_valid_s1 && !scan_done;
	assign drain_hit  = chk_go && is_drain && ram_rdata[IDENT_W];
	assign remove_hit = chk_go && !is_drain && key_hit;
	assign emit_mid   = drain_hit && pend_valid_q;
	assign stall      = emit_mid && !can_load;
	assign issue      = (state_q == S_SCAN) && !scan_done && !remove_hit && !stall &&
		(scan_idx_q != tail_q);

	// slot RAM port selection
	always_comb begin
		ram_we    = app_write || remove_hit;
		ram_waddr = remove_hit ? chk_idx_s1 : tail_q[AW-1:0];
		ram_wdata = remove_hit ? {1'b0, ram_rdata[IDENT_W-1:0]} : {1'b1, in_data.ident};
		ram_re    = issue;
	end

	// result word selection
	always_comb begin
		out_load  = 1'b0;
		load_data = res_q;
		if (state_q == S_FINAL) begin
			out_load = 1'b1;
		end else if (emit_mid) begin
			out_load  = 1'b1;
			load_data = '{status: ST_OK, entry_ident: pend_ident_q,
				entry_valid: 1'b1, last: 1'b0};
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			tail_q       <= '0;
			scan_idx_q   <= '0;
			chk_valid_s1 <= 1'b0;
			pend_valid_q <= 1'b0;
			found_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (app_write) begin
							tail_q <= tail_q + CNT_W'(1);
						end
						if (in_data.operation == OP_REMOVE ||
							in_data.operation == OP_DRAIN) begin
							scan_idx_q   <= '0;
							chk_valid_s1 <= 1'b0;
							pend_valid_q <= 1'b0;
							found_q      <= '0;
							state_q      <= S_SCAN;
						end else begin
							state_q <= S_FINAL;
						end
					end
				end
				S_SCAN: begin
					if (scan_done) begin
						if (is_drain) begin
							tail_q <= '0;
						end
						state_q <= S_FINAL;
					end else if (remove_hit) begin
						state_q <= S_FINAL;
					end else if (!stall) begin
						chk_valid_s1 <= issue;
						if (issue) begin
							scan_idx_q <= scan_idx_q + CNT_W'(1);
						end
						if (drain_hit) begin
							pend_valid_q <= 1'b1;
							found_q      <= found_q + RES_W'(1);
						end
					end
				end
				S_FINAL: begin
					if (can_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// operand and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= in_data.operation;
			key_q <= in_data.ident;
			res_q <= '{status: (in_data.operation == OP_APPEND && is_full) ? ST_FULL : ST_OK,
				entry_ident: '0, entry_valid: 1'b0, last: 1'b1};
		end
		if (state_q == S_SCAN) begin
			if (!stall) begin
				chk_idx_s1 <= scan_idx_q[AW-1:0];
			end
			if (drain_hit && !stall) begin
				pend_ident_q <= ram_rdata[IDENT_W-1:0];
			end
			if (scan_done) begin
				if (is_drain && pend_valid_q) begin
					res_q <= '{status: ST_OK, entry_ident: pend_ident_q,
						entry_valid: 1'b1, last: 1'b1};
				end else if (is_drain) begin
					res_q <= '{status: ST_OK, entry_ident: '0, entry_valid: 1'b0,
						last: 1'b1};
				end else begin
					res_q <= '{status: ST_NOT_FOUND, entry_ident: '0,
						entry_valid: 1'b0, last: 1'b1};
				end
			end else if (remove_hit) begin
				res_q <= '{status: ST_OK, entry_ident: '0, entry_valid: 1'b0, last: 1'b1};
			end
		end
	end

	oqrk_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (scan_idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	oqrk_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (out_load),
		.load_data (load_data),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

/* sv/oqrk_checker.sv */
// ----------------------------------------------------------------------------
// oqrk_checker
// Port-level checks of the queue's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module oqrk_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input oqrk_pkg::out_word_t out_data
);
	import oqrk_pkg::*;

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// busy after taking an input word
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a word is in progress");

	// identifier field is zero unless it carries a drained entry
	a_ident_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.entry_valid |-> out_data.entry_ident == '0)
		else $error("entry_ident set without entry_valid");

	// only drained entries may precede the final word
	a_mid_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last |-> out_data.entry_valid && out_data.status == ST_OK)
		else $error("non-final result word is not a drained entry");

	// a drained entry never comes with a failure status
	a_entry_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.entry_valid |-> out_data.status == ST_OK)
		else $error("drained entry with failure status");

endmodule

bind ordered_queue_remove_by_key_top oqrk_checker u_oqrk_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

/* sim/oqrk_queue_checker.sv */
// ----------------------------------------------------------------------------
// oqrk_queue_checker
// Watches both channels of the ordered queue, tracks the queue contents
// and compares every result word with the predicted one, in order.
// ----------------------------------------------------------------------------
module oqrk_queue_checker #(
	parameter int unsigned CAPACITY = oqrk_pkg::CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  oqrk_pkg::in_word_t  in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  oqrk_pkg::out_word_t out_data,
	output int                  fail_count,
	output int                  words_due,
	output int                  words_seen
);
	import oqrk_pkg::*;

	// mirrored queue: identifiers, live flags and the tail slot
	logic [IDENT_W-1:0] slot_ident [CAPACITY];
	logic               slot_live  [CAPACITY];
	int unsigned        tail = 0;

	// predicted result words, oldest first
	out_word_t due_words [$];
	int        errs = 0;
	int        seen = 0;

	function automatic out_word_t result_word(logic [1:0] st, logic [IDENT_W-1:0] id,
			logic ev, logic lst);
		out_word_t w;
		w.status      = st;
		w.entry_ident = id;
		w.entry_valid = ev;
		w.last        = lst;
		return w;
	endfunction

	// apply one input word to the mirrored queue and queue up its results
	function automatic void apply_queue_op(in_word_t w);
		int unsigned i;
		int          n;
		bit          hit;
		bit          held;
		out_word_t   pend;
		n    = 0;
		hit  = 1'b0;
		held = 1'b0;
		pend = '0;
		case (w.operation)
			OP_APPEND: begin
				if (tail >= CAPACITY) begin
					due_words.push_back(result_word(ST_FULL, '0, 1'b0, 1'b1));
				end else begin
					slot_ident[tail] = w.ident;
					slot_live[tail]  = 1'b1;
					tail++;
					due_words.push_back(result_word(ST_OK, '0, 1'b0, 1'b1));
				end
			end
			OP_REMOVE: begin
				// clear only the oldest live match
				for (i = 0; i < tail; i++) begin
					if (!hit && slot_live[i] && slot_ident[i] == w.ident) begin
						slot_live[i] = 1'b0;
						hit = 1'b1;
					end
				end
				due_words.push_back(result_word(hit ? ST_OK : ST_NOT_FOUND, '0, 1'b0, 1'b1));
			end
			OP_DRAIN: begin
				// hold back one word so the final one can carry last
				for (i = 0; i < tail; i++) begin
					if (slot_live[i] && n < MAX_RESULTS) begin
						if (held)
							due_words.push_back(pend);
						pend = result_word(ST_OK, slot_ident[i], 1'b1, 1'b0);
						held = 1'b1;
						n++;
					end
				end
				if (held)
					pend.last = 1'b1;
				else
					pend = result_word(ST_OK, '0, 1'b0, 1'b1);
				due_words.push_back(pend);
				for (i = 0; i < CAPACITY; i++)
					slot_live[i] = 1'b0;
				tail = 0;
			end
			default: begin
				due_words.push_back(result_word(ST_OK, '0, 1'b0, 1'b1));
			end
		endcase
	endfunction

	// count one mismatch and print it if among the first 30
	task automatic flag_mismatch(string what, logic [IDENT_W-1:0] got,
			logic [IDENT_W-1:0] want);
		errs++;
		if (errs <= 30)
			$display("mismatch in %s at result word %0d: got %h, want %h",
				what, seen, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_word_t   want;
		int unsigned k;
		if (!arst_n) begin
			for (k = 0; k < CAPACITY; k++)
				slot_live[k] = 1'b0;
			tail = 0;
			due_words.delete();
		end else begin
			// take the input word first; its results can never leave in the same cycle
			if (in_valid && in_ready)
				apply_queue_op(in_data);
			// compare an accepted result word with the oldest prediction
			if (out_valid && out_ready) begin
				if (due_words.size() == 0) begin
					flag_mismatch("unexpected word", out_data.entry_ident, '0);
				end else begin
					want = due_words.pop_front();
					if (out_data.status !== want.status)
						flag_mismatch("status", IDENT_W'(out_data.status),
							IDENT_W'(want.status));
					if (out_data.entry_ident !== want.entry_ident)
						flag_mismatch("entry_ident", out_data.entry_ident, want.entry_ident);
					if (out_data.entry_valid !== want.entry_valid)
						flag_mismatch("entry_valid", IDENT_W'(out_data.entry_valid),
							IDENT_W'(want.entry_valid));
					if (out_data.last !== want.last)
						flag_mismatch("last", IDENT_W'(out_data.last), IDENT_W'(want.last));
				end
				seen++;
			end
		end
		fail_count <= errs;
		words_due  <= due_words.size();
		words_seen <= seen;
	end

endmodule

/* sim/tb_ordered_queue_remove_by_key_top.sv */
// ----------------------------------------------------------------------------
// tb_ordered_queue_remove_by_key_top
// Drives append, remove, drain and unused-code words into the ordered queue
// with random gaps and output stalls; a checker beside the block predicts
// and compares every result word.
// ----------------------------------------------------------------------------
module tb_ordered_queue_remove_by_key_top;
	import oqrk_pkg::*;

	localparam int unsigned SLOTS        = CAPACITY_DEF;
	localparam int          RANDOM_WORDS = 165;
	localparam int          CYCLE_LIMIT  = 400000;
	// the one code the block treats as a no-op
	localparam logic [1:0]  OP_UNUSED    = 2'd3;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_word_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_data;

	int fail_count;
	int words_due;
	int words_seen;
	int cycles = 0;

	// no idling on either side while set
	logic steady = 1'b0;

	// live identifiers in arrival order, to aim removes and fills
	logic [IDENT_W-1:0] held_ids [$];
	int unsigned        slots_used = 0;
	int                 words_sent = 0;
	int                 n_append   = 0;
	int                 n_remove   = 0;
	int                 n_drain    = 0;
	int                 n_unused   = 0;

	ordered_queue_remove_by_key_top #(
		.CAPACITY(SLOTS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	oqrk_queue_checker #(
		.CAPACITY(SLOTS)
	) queue_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.fail_count(fail_count),
		.words_due (words_due),
		.words_seen(words_seen)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// stall the result side about a third of the time
	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= 32);
	end

	// end the run if it hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// half the time a small pool so removes hit and duplicates occur
	function automatic logic [IDENT_W-1:0] random_ident();
		if ($urandom_range(1))
			return IDENT_W'($urandom_range(15));
		return $urandom();
	endfunction

	// send one word and wait for its accept
	task automatic push_word(logic [1:0] op, logic [IDENT_W-1:0] id);
		int          gap;
		int unsigned k;
		bit          hit;
		gap = 0;
		hit = 1'b0;
		if (!steady && $urandom_range(99) < 32)
			gap = $urandom_range(1, 3);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= {op, id};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		words_sent++;
		// follow the queue contents for later stimulus choices
		case (op)
			OP_APPEND: begin
				n_append++;
				if (slots_used < SLOTS) begin
					held_ids.push_back(id);
					slots_used++;
				end
			end
			OP_REMOVE: begin
				n_remove++;
				for (k = 0; k < held_ids.size(); k++) begin
					if (!hit && held_ids[k] == id) begin
						held_ids.delete(k);
						hit = 1'b1;
					end
				end
			end
			OP_DRAIN: begin
				n_drain++;
				held_ids.delete();
				slots_used = 0;
			end
			default: n_unused++;
		endcase
	endtask

	// append until every slot is used
	task automatic fill_queue();
		while (slots_used < SLOTS)
			push_word(OP_APPEND, random_ident());
	endtask

	initial begin
		int                 first_random;
		int                 pick;
		int                 fills;
		logic [IDENT_W-1:0] id;
		fills = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue, unused code and field extremes
		push_word(OP_DRAIN, '0);
		push_word(OP_UNUSED, '1);
		push_word(OP_REMOVE, '0);
		push_word(OP_APPEND, '0);
		push_word(OP_APPEND, '1);
		push_word(OP_APPEND, 32'h5a5a_5a5a);
		push_word(OP_APPEND, 32'h5a5a_5a5a);
		push_word(OP_APPEND, 32'ha5a5_a5a5);
		// duplicate: only the oldest goes
		push_word(OP_REMOVE, 32'h5a5a_5a5a);
		push_word(OP_REMOVE, 32'h1234_5678);
		push_word(OP_REMOVE, '0);
		push_word(OP_DRAIN, '1);
		push_word(OP_REMOVE, '1);
		push_word(OP_UNUSED, '0);

		// full queue, holes that do not free space, tail slot removal
		fill_queue();
		push_word(OP_APPEND, '1);
		push_word(OP_REMOVE, held_ids[30]);
		push_word(OP_REMOVE, held_ids[0]);
		push_word(OP_APPEND, 32'h0000_0007);
		push_word(OP_REMOVE, held_ids[held_ids.size() - 1]);
		push_word(OP_DRAIN, '0);
		// drain with used slots but nothing live
		push_word(OP_APPEND, 32'h0000_0001);
		push_word(OP_REMOVE, 32'h0000_0001);
		push_word(OP_DRAIN, '0);

		// random mix of short sequences
		first_random = words_sent;
		while (words_sent - first_random < RANDOM_WORDS) begin
			steady = (words_sent - first_random >= 80) && (words_sent - first_random < 140);
			pick = $urandom_range(99);
			if (pick < 45) begin
				push_word(OP_APPEND, random_ident());
			end else if (pick < 75) begin
				if (held_ids.size() != 0 && $urandom_range(4) != 0)
					id = held_ids[$urandom_range(held_ids.size() - 1)];
				else
					id = random_ident();
				push_word(OP_REMOVE, id);
			end else if (pick < 85) begin
				push_word(OP_DRAIN, $urandom());
			end else if (pick < 88) begin
				push_word(OP_UNUSED, $urandom());
			end else if (pick < 92 && fills < 2) begin
				fill_queue();
				push_word(OP_APPEND, $urandom());
				if (held_ids.size() != 0)
					push_word(OP_REMOVE, held_ids[$urandom_range(held_ids.size() - 1)]);
				push_word(OP_APPEND, $urandom());
				fills++;
			end else begin
				push_word(OP_APPEND, $urandom_range(1) ? '0 : '1);
			end
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		// let the checker see the last accept, then wait for every result
		@(posedge clk);
		while (words_due != 0) @(posedge clk);
		repeat (SLOTS + 8) @(posedge clk);

		$display("sent %0d appends, %0d removes, %0d drains, %0d unused-code words",
			n_append, n_remove, n_drain, n_unused);
		$display("compared %0d result words against the tracked queue", words_seen);
		if (fail_count == 0 && words_due == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
